>>> rtl/core/voice_mix_smooth_silence_detect_assert.svh
// Assertion macros for the voice mix smoothing and silence detection block
`ifndef VOICE_MIX_SMOOTH_SILENCE_DETECT_ASSERT_SVH
`define VOICE_MIX_SMOOTH_SILENCE_DETECT_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while reset is low
`define VMSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VMSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Implication with a fixed delay in cycles
`define VMSD_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

>>> rtl/core/vmsd_pkg.sv
// Shared widths, reset values, register indexes and control struct
`default_nettype none

package vmsd_pkg;

    // Lane layout
    localparam int MAX_LANES = 8;
    localparam int LANES     = 8;
    localparam int SAMPLE_W  = 16;
    localparam int MIX_W     = SAMPLE_W + $clog2(MAX_LANES);

    // Filter datapath
    localparam int Q_W      = 16;
    localparam int COEF_W   = Q_W + 1;
    localparam int LEVEL_W  = 36;
    localparam int DIFF_W   = LEVEL_W + 1;
    localparam int PLO_W    = COEF_W + Q_W;
    localparam int STEP_W   = COEF_W + 1 + DIFF_W - Q_W;
    localparam int LSUM_W   = STEP_W + 1;
    localparam int V_W      = LEVEL_W - Q_W;

    // Energy datapath
    localparam int SQ_W         = 2 * V_W - 1;
    localparam int ENERGY_FRAC  = 8;
    localparam int EN_W         = 48;
    localparam int ED_W         = EN_W + 1;
    localparam int ELO_W        = 2 * Q_W;
    localparam int ESTEP_W      = Q_W + 1 + ED_W - Q_W;
    localparam int THR_W        = 32;
    localparam int HOLD_W       = 17;

    // Saturation limits
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [HOLD_W-1:0] RUN_MAX = {HOLD_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_BASE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SPAN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_ALPHA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_HOLD      = 3'd4;

    localparam logic [Q_W-1:0]    RST_CUTOFF_BASE       = 16'd1966;
    localparam logic [Q_W-1:0]    RST_CUTOFF_SPAN       = 16'd13107;
    localparam logic [Q_W-1:0]    RST_ENERGY_ALPHA      = 16'd52;
    localparam logic [THR_W-1:0]  RST_SILENCE_THRESHOLD = 32'd18000;
    localparam logic [HOLD_W-1:0] RST_SILENCE_HOLD      = 17'd16000;

    // One enable per datapath step, driven by the sequencer
    typedef struct packed {
        logic load;
        logic coef;
        logic diff;
        logic plo;
        logic phi;
        logic lvl;
        logic vcv;
        logic sq;
        logic edif;
        logic elo;
        logic ehi;
        logic eupd;
        logic commit;
    } vmsd_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/vmsd_lane.sv
// One voice lane: gates the sample by its valid bit and holds it
`default_nettype none

module vmsd_lane
    import vmsd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic                       lane_en,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0]      gated
);

    logic signed [SAMPLE_W-1:0] gated_reg;
    logic signed [SAMPLE_W-1:0] gated_next;

    // Idle lanes contribute zero to the mix
    assign gated_next = lane_en ? sample : '0;

    always_ff @(posedge aclk) begin
        if (load) begin
            gated_reg <= gated_next;
        end
    end

    assign gated = gated_reg;

endmodule

`default_nettype wire

>>> rtl/core/vmsd_merge.sv
// Merge stage: sums the gated lane samples into the mix
`default_nettype none

module vmsd_merge
    import vmsd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic signed [SAMPLE_W-1:0] lane_sample [LANES],
    output logic signed [MIX_W-1:0]         mix
);

    logic signed [MIX_W-1:0] mix_reg;
    logic signed [MIX_W-1:0] mix_next;
    logic signed [MIX_W-1:0] lane_ext [LANES];

    // Sign-extend each lane to the mix width
    for (genvar g = 0; g < LANES; g++) begin : g_ext
        assign lane_ext[g] = MIX_W'(lane_sample[g]);
    end

    always_comb begin
        mix_next = '0;
        for (int i = 0; i < LANES; i++) begin
            mix_next = mix_next + lane_ext[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mix_reg <= mix_next;
        end
    end

    assign mix = mix_reg;

endmodule

`default_nettype wire

>>> rtl/core/vmsd_filter.sv
// One-pole smoothing filter: coefficient, split product, saturating level
`default_nettype none

module vmsd_filter
    import vmsd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire vmsd_ctrl_t              ctrl,
    input  wire logic [Q_W-1:0]          macro_mod,
    input  wire logic [Q_W-1:0]          cutoff_base,
    input  wire logic [Q_W-1:0]          cutoff_span,
    input  wire logic signed [MIX_W-1:0] mix,
    output logic signed [V_W-1:0]        v_level,
    output logic signed [SAMPLE_W-1:0]   out_sample
);

    logic [Q_W-1:0]              mod_reg;
    logic [COEF_W-1:0]           coef_reg;
    logic [COEF_W-1:0]           coef_next;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic signed [DIFF_W-1:0]    diff_next;
    logic [PLO_W-1:0]            plo_reg;
    logic [PLO_W-1:0]            plo_next;
    logic signed [STEP_W-1:0]    step_reg;
    logic signed [STEP_W-1:0]    step_next;
    logic signed [LEVEL_W-1:0]   level_reg;
    logic signed [LEVEL_W-1:0]   level_next;
    logic signed [V_W-1:0]       v_reg;
    logic signed [V_W-1:0]       v_next;

    logic [2*Q_W-1:0]               mod_prod;
    logic signed [DIFF_W-Q_W-1:0]   mix_ext;
    logic signed [DIFF_W-1:0]       level_ext;
    logic signed [COEF_W:0]         coef_s;
    logic signed [DIFF_W-Q_W-1:0]   diff_hi;
    logic signed [STEP_W-1:0]       mul_hi;
    logic signed [STEP_W-1:0]       plo_top;
    logic signed [LSUM_W-1:0]       lvl_sum;
    logic [LSUM_W-LEVEL_W:0]        lvl_top;
    logic                           v_inc;
    logic [V_W-SAMPLE_W:0]          v_top;

    // Coefficient: base + span * mod / 2^16
    assign mod_prod  = (2*Q_W)'(cutoff_span * mod_reg);
    assign coef_next = {1'b0, cutoff_base} + {1'b0, mod_prod[2*Q_W-1:Q_W]};

    // Distance from level to the scaled mix
    assign mix_ext   = (DIFF_W-Q_W)'(mix);
    assign level_ext = DIFF_W'(level_reg);
    assign diff_next = $signed({mix_ext, {Q_W{1'b0}}}) - level_ext;

    // Low partial product over the unsigned low half of diff
    assign plo_next = PLO_W'(coef_reg * diff_reg[Q_W-1:0]);

    // High partial product, then floor(coef * diff / 2^16)
    assign coef_s    = {1'b0, coef_reg};
    assign diff_hi   = diff_reg[DIFF_W-1:Q_W];
    assign mul_hi    = STEP_W'(coef_s * diff_hi);
    assign plo_top   = {{(STEP_W-COEF_W){1'b0}}, plo_reg[PLO_W-1:Q_W]};
    assign step_next = mul_hi + plo_top;

    // Level update with saturation to the signed level range
    assign lvl_sum = LSUM_W'(level_reg + step_reg);
    assign lvl_top = lvl_sum[LSUM_W-1:LEVEL_W-1];

    always_comb begin
        if (lvl_top != '0 && lvl_top != '1) begin
            level_next = lvl_sum[LSUM_W-1] ? LEVEL_MIN : LEVEL_MAX;
        end else begin
            level_next = lvl_sum[LEVEL_W-1:0];
        end
    end

    // Integer part, truncated toward zero
    assign v_inc  = level_reg[LEVEL_W-1] & (|level_reg[Q_W-1:0]);
    assign v_next = level_reg[LEVEL_W-1:Q_W] + {{(V_W-1){1'b0}}, v_inc};

    // Clamp to int16
    assign v_top = v_reg[V_W-1:SAMPLE_W-1];

    always_comb begin
        if (v_top != '0 && v_top != '1) begin
            out_sample = v_reg[V_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            out_sample = v_reg[SAMPLE_W-1:0];
        end
    end

    // Datapath registers, one step each
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            mod_reg <= macro_mod;
        end
        if (ctrl.coef) begin
            coef_reg <= coef_next;
        end
        if (ctrl.diff) begin
            diff_reg <= diff_next;
        end
        if (ctrl.plo) begin
            plo_reg <= plo_next;
        end
        if (ctrl.phi) begin
            step_reg <= step_next;
        end
        if (ctrl.vcv) begin
            v_reg <= v_next;
        end
    end

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (ctrl.lvl) begin
            level_reg <= level_next;
        end
    end

    assign v_level = v_reg;

endmodule

`default_nettype wire

>>> rtl/core/vmsd_energy.sv
// Energy average of the squared output and silent-run tracking
`default_nettype none

module vmsd_energy
    import vmsd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire vmsd_ctrl_t            ctrl,
    input  wire logic signed [V_W-1:0] v_level,
    input  wire logic [Q_W-1:0]        energy_alpha,
    input  wire logic [THR_W-1:0]      silence_threshold,
    input  wire logic [HOLD_W-1:0]     silence_hold,
    output logic                       is_silent,
    output logic                       recover
);

    logic [SQ_W-1:0]             sq_reg;
    logic signed [ED_W-1:0]      ediff_reg;
    logic signed [ED_W-1:0]      ediff_next;
    logic [ELO_W-1:0]            elo_reg;
    logic [ELO_W-1:0]            elo_next;
    logic signed [ESTEP_W-1:0]   estep_reg;
    logic signed [ESTEP_W-1:0]   estep_next;
    logic [EN_W-1:0]             energy_reg;
    logic [EN_W-1:0]             energy_next;
    logic [HOLD_W-1:0]           run_reg;
    logic [HOLD_W-1:0]           run_next;

    logic signed [2*V_W-1:0]     sq_full;
    logic signed [Q_W:0]         alpha_s;
    logic signed [ED_W-Q_W-1:0]  ed_hi;
    logic signed [ESTEP_W-1:0]   emul;
    logic signed [ESTEP_W-1:0]   elo_top;
    logic signed [ESTEP_W:0]     energy_s;
    logic signed [ESTEP_W:0]     e_sum;
    logic [EN_W-1:0]             thr_scaled;
    logic [HOLD_W-1:0]           run_inc;
    logic [HOLD_W-1:0]           hold_eff;

    // Square of the output value
    assign sq_full = (2*V_W)'(v_level * v_level);

    // E' = E + floor(alpha * (sq * 2^8 - E) / 2^16)
    assign ediff_next = $signed({{(ED_W-SQ_W-ENERGY_FRAC){1'b0}}, sq_reg,
                                 {ENERGY_FRAC{1'b0}}})
                      - $signed({1'b0, energy_reg});

    assign elo_next = ELO_W'(energy_alpha * ediff_reg[Q_W-1:0]);

    assign alpha_s    = {1'b0, energy_alpha};
    assign ed_hi      = ediff_reg[ED_W-1:Q_W];
    assign emul       = ESTEP_W'(alpha_s * ed_hi);
    assign elo_top    = {{(ESTEP_W-Q_W){1'b0}}, elo_reg[ELO_W-1:Q_W]};
    assign estep_next = emul + elo_top;

    assign energy_s    = {{(ESTEP_W+1-EN_W){1'b0}}, energy_reg};
    assign e_sum       = (ESTEP_W+1)'(energy_s + estep_reg);
    assign energy_next = e_sum[EN_W-1:0];

    // Silence test on the updated average
    assign thr_scaled = {{(EN_W-THR_W-ENERGY_FRAC){1'b0}}, silence_threshold,
                         {ENERGY_FRAC{1'b0}}};
    assign is_silent  = energy_reg < thr_scaled;

    // Run counter; a zero hold behaves as one
    assign hold_eff = (silence_hold == '0) ? {{(HOLD_W-1){1'b0}}, 1'b1} : silence_hold;

    always_comb begin
        if (!is_silent) begin
            run_inc = '0;
        end else if (run_reg == RUN_MAX) begin
            run_inc = run_reg;
        end else begin
            run_inc = run_reg + {{(HOLD_W-1){1'b0}}, 1'b1};
        end
    end

    assign recover  = run_inc >= hold_eff;
    assign run_next = recover ? '0 : run_inc;

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (ctrl.sq) begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (ctrl.edif) begin
            ediff_reg <= ediff_next;
        end
        if (ctrl.elo) begin
            elo_reg <= elo_next;
        end
        if (ctrl.ehi) begin
            estep_reg <= estep_next;
        end
    end

    // Detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= '0;
            run_reg    <= '0;
        end else begin
            if (ctrl.eupd) begin
                energy_reg <= energy_next;
            end
            if (ctrl.commit) begin
                run_reg <= run_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/voice_mix_smooth_silence_detect.sv
// Each accepted transaction steps through the sequencer states COEF, DIFF, PLO, PHI, LVL,
//   VCV, SQ, EDIF, ELO, EHI, EUPD and DONE in order, set by the chain of dependent multiplies
//   in the level and energy updates; a new one is accepted only after DONE commits, which waits on m_ready.
// Reset (aresetn low, synchronous): level, energy and silent run clear to zero,
//   registers return to their defaults, the output register empties.
`default_nettype none

`include "voice_mix_smooth_silence_detect_assert.svh"

module voice_mix_smooth_silence_detect
    import vmsd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [MAX_LANES-1:0]       s_lane_valid,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_0,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_1,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_2,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_3,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_4,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_5,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_6,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_7,
    input  wire logic [Q_W-1:0]             s_macro_mod,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_out_sample,
    output logic                            m_recover,
    output logic                            m_is_silent
);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0_0000_0000_0001,
        ST_COEF = 13'b0_0000_0000_0010,
        ST_DIFF = 13'b0_0000_0000_0100,
        ST_PLO  = 13'b0_0000_0000_1000,
        ST_PHI  = 13'b0_0000_0001_0000,
        ST_LVL  = 13'b0_0000_0010_0000,
        ST_VCV  = 13'b0_0000_0100_0000,
        ST_SQ   = 13'b0_0000_1000_0000,
        ST_EDIF = 13'b0_0001_0000_0000,
        ST_ELO  = 13'b0_0010_0000_0000,
        ST_EHI  = 13'b0_0100_0000_0000,
        ST_EUPD = 13'b0_1000_0000_0000,
        ST_DONE = 13'b1_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [Q_W-1:0]    cutoff_base_reg;
    logic [Q_W-1:0]    cutoff_span_reg;
    logic [Q_W-1:0]    energy_alpha_reg;
    logic [THR_W-1:0]  silence_threshold_reg;
    logic [HOLD_W-1:0] silence_hold_reg;

    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic signed [SAMPLE_W-1:0] m_out_sample_reg;
    logic                       m_recover_reg;
    logic                       m_is_silent_reg;

    vmsd_ctrl_t ctrl;

    logic signed [SAMPLE_W-1:0] samp_in  [MAX_LANES];
    logic signed [SAMPLE_W-1:0] lane_out [LANES];
    logic signed [MIX_W-1:0]    mix;
    logic signed [V_W-1:0]      v_level;
    logic signed [SAMPLE_W-1:0] filt_out;
    logic                       det_silent;
    logic                       det_recover;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_base_reg       <= RST_CUTOFF_BASE;
            cutoff_span_reg       <= RST_CUTOFF_SPAN;
            energy_alpha_reg      <= RST_ENERGY_ALPHA;
            silence_threshold_reg <= RST_SILENCE_THRESHOLD;
            silence_hold_reg      <= RST_SILENCE_HOLD;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CUTOFF_BASE:       cutoff_base_reg       <= cfg_data[Q_W-1:0];
                CFG_CUTOFF_SPAN:       cutoff_span_reg       <= cfg_data[Q_W-1:0];
                CFG_ENERGY_ALPHA:      energy_alpha_reg      <= cfg_data[Q_W-1:0];
                CFG_SILENCE_THRESHOLD: silence_threshold_reg <= cfg_data[THR_W-1:0];
                CFG_SILENCE_HOLD:      silence_hold_reg      <= cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Step sequencer
    assign s_ready = (state_reg == ST_IDLE);

    assign ctrl.load   = s_valid && s_ready;
    assign ctrl.coef   = (state_reg == ST_COEF);
    assign ctrl.diff   = (state_reg == ST_DIFF);
    assign ctrl.plo    = (state_reg == ST_PLO);
    assign ctrl.phi    = (state_reg == ST_PHI);
    assign ctrl.lvl    = (state_reg == ST_LVL);
    assign ctrl.vcv    = (state_reg == ST_VCV);
    assign ctrl.sq     = (state_reg == ST_SQ);
    assign ctrl.edif   = (state_reg == ST_EDIF);
    assign ctrl.elo    = (state_reg == ST_ELO);
    assign ctrl.ehi    = (state_reg == ST_EHI);
    assign ctrl.eupd   = (state_reg == ST_EUPD);
    assign ctrl.commit = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_PLO;
            ST_PLO:  state_next = ST_PHI;
            ST_PHI:  state_next = ST_LVL;
            ST_LVL:  state_next = ST_VCV;
            ST_VCV:  state_next = ST_SQ;
            ST_SQ:   state_next = ST_EDIF;
            ST_EDIF: state_next = ST_ELO;
            ST_ELO:  state_next = ST_EHI;
            ST_EHI:  state_next = ST_EUPD;
            ST_EUPD: state_next = ST_DONE;
            ST_DONE: begin
                if (ctrl.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Voice lanes
    assign samp_in[0] = s_sample_0;
    assign samp_in[1] = s_sample_1;
    assign samp_in[2] = s_sample_2;
    assign samp_in[3] = s_sample_3;
    assign samp_in[4] = s_sample_4;
    assign samp_in[5] = s_sample_5;
    assign samp_in[6] = s_sample_6;
    assign samp_in[7] = s_sample_7;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vmsd_lane u_lane (
            .aclk    (aclk),
            .load    (ctrl.load),
            .lane_en (s_lane_valid[g]),
            .sample  (samp_in[g]),
            .gated   (lane_out[g])
        );
    end

    vmsd_merge u_merge (
        .aclk        (aclk),
        .en          (ctrl.coef),
        .lane_sample (lane_out),
        .mix         (mix)
    );

    vmsd_filter u_filter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .macro_mod   (s_macro_mod),
        .cutoff_base (cutoff_base_reg),
        .cutoff_span (cutoff_span_reg),
        .mix         (mix),
        .v_level     (v_level),
        .out_sample  (filt_out)
    );

    vmsd_energy u_energy (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .v_level           (v_level),
        .energy_alpha      (energy_alpha_reg),
        .silence_threshold (silence_threshold_reg),
        .silence_hold      (silence_hold_reg),
        .is_silent         (det_silent),
        .recover           (det_recover)
    );

    // Output register
    always_comb begin
        if (ctrl.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            m_out_sample_reg <= filt_out;
            m_recover_reg    <= det_recover;
            m_is_silent_reg  <= det_silent;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_out_sample_reg;
    assign m_recover    = m_recover_reg;
    assign m_is_silent  = m_is_silent_reg;

    // Checks
    `VMSD_ASSERT_DLY(a_accept_to_done, s_valid && s_ready, 12, state_reg == ST_DONE,
                     "accepted transaction did not reach the result step in 12 cycles")
    `VMSD_ASSERT_IMP(a_recover_silent, m_valid && m_recover, m_is_silent,
                     "recover pulse without silence")
    `VMSD_ASSERT_NXT(a_done_stall, state_reg == ST_DONE && m_valid && !m_ready,
                     state_reg == ST_DONE, "finished result left while output was blocked")

endmodule

`default_nettype wire
